// ----- rtl/rgbhsi_pkg.sv -----
// ---------------------------------------------------------------------------
// rgbhsi_pkg
// Types, constants and tables shared by the RGB to HSI converter.
// ---------------------------------------------------------------------------
package rgbhsi_pkg;

    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 19;
    localparam int CORDIC_STEPS = 18;
    localparam int STEP_W = 5;

    localparam logic [18:0] MAX_FRAME_PIXELS = 19'd262144;
    localparam logic [15:0] SAT_SCALE = 16'd65280;
    localparam logic [16:0] SQRT3_Q16 = 17'd113512;
    localparam logic signed [26:0] ANGLE_90 = 27'sd5898240;
    localparam logic signed [26:0] ANGLE_180 = 27'sd11796480;
    localparam logic [24:0] ANGLE_360 = 25'd23592960;
    localparam logic [17:0] HUE_RECIP = 18'd174763;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  intensity;
        logic [7:0]  saturation;
        logic [7:0]  hue;
        logic        frame_done;
        logic [15:0] mean_intensity;
        logic [15:0] mean_saturation;
        logic [15:0] mean_hue;
    } result_t;

    typedef struct packed {
        logic [15:0]        iq;
        logic [25:0]        sat_num;
        logic [9:0]         tsum;
        logic               gray;
        logic               b_gt_g;
        logic               last;
        logic signed [27:0] x0;
        logic signed [27:0] y0;
        logic signed [26:0] z0;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAT,
        ST_CORDIC,
        ST_HUE_START,
        ST_HUE,
        ST_ACCUM,
        ST_MEAN_START,
        ST_MEAN,
        ST_OUT
    } state_t;

    function automatic logic signed [26:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic signed [26:0] a;
        case (idx)
            5'd0:    a = 27'sd2949120;
            5'd1:    a = 27'sd1740967;
            5'd2:    a = 27'sd919879;
            5'd3:    a = 27'sd466945;
            5'd4:    a = 27'sd234379;
            5'd5:    a = 27'sd117304;
            5'd6:    a = 27'sd58666;
            5'd7:    a = 27'sd29335;
            5'd8:    a = 27'sd14668;
            5'd9:    a = 27'sd7334;
            5'd10:   a = 27'sd3667;
            5'd11:   a = 27'sd1833;
            5'd12:   a = 27'sd917;
            5'd13:   a = 27'sd458;
            5'd14:   a = 27'sd229;
            5'd15:   a = 27'sd115;
            5'd16:   a = 27'sd57;
            5'd17:   a = 27'sd29;
            default: a = 27'sd0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/rgbhsi_front.sv -----
// ---------------------------------------------------------------------------
// rgbhsi_front
// Classifies an incoming pixel and prepares the operands of its conversion.
// ---------------------------------------------------------------------------
module rgbhsi_front
    import rgbhsi_pkg::*;
(
    input  pixel_t pixel,
    output item_t  item
);

    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [9:0]         t;
    logic [7:0]         m;
    logic [7:0]         d;
    logic [19:0]        t_third;
    logic [15:0]        t_85;
    logic signed [10:0] xd;
    logic signed [27:0] xs;
    logic signed [27:0] ys;
    logic [24:0]        y_prod;
    logic [9:0]         spread;

    always_comb
    begin
        r = pixel.red;
        g = pixel.green;
        b = pixel.blue;
        t = {2'b0, r} + {2'b0, g} + {2'b0, b};
        m = (r < g) ? r : g;
        if (b < m)
        begin
            m = b;
        end
        d = (g >= b) ? (g - b) : (b - g);
        t_85 = 16'(t) * 16'd85;
        t_third = 20'(t) * 20'd683;
        spread = t - (10'(m) * 10'd3);
        xd = $signed({2'b0, r, 1'b0}) - $signed({3'b0, g}) - $signed({3'b0, b});
        xs = {xd[10], xd, 16'b0};
        y_prod = 25'(d) * 25'(SQRT3_Q16);
        ys = $signed({3'b0, y_prod});

        item.iq = t_85 + {5'b0, t_third[19:9] >> 2};
        item.sat_num = 26'(spread) * 26'(SAT_SCALE);
        item.tsum = t;
        item.gray = (r == g) && (g == b);
        item.b_gt_g = b > g;
        item.last = pixel.last_pixel;
        if (xd < 0)
        begin
            item.x0 = ys;
            item.y0 = -xs;
            item.z0 = ANGLE_90;
        end
        else
        begin
            item.x0 = xs;
            item.y0 = ys;
            item.z0 = 27'sd0;
        end
    end

endmodule

// ----- rtl/rgbhsi_fifo.sv -----
// ---------------------------------------------------------------------------
// rgbhsi_fifo
// Two-entry queue that decouples the front classifier from the back engine.
// ---------------------------------------------------------------------------
module rgbhsi_fifo
    import rgbhsi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  item_t        wr_item,
    input  logic         rd,
    output item_t        rd_item,
    output fifo_status_t status
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;
    logic       do_wr;
    logic       do_rd;

    assign status.full = level_reg == 2'd2;
    assign status.empty = level_reg == 2'd0;
    assign do_wr = wr && !status.full;
    assign do_rd = rd && !status.empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                level_reg <= level_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                level_reg <= level_reg - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/rgbhsi_div.sv -----
// ---------------------------------------------------------------------------
// rgbhsi_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rgbhsi_div
    import rgbhsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   shifted;
    logic                 qbit;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
        qbit = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], qbit};
            if (qbit)
            begin
                rem_reg <= DIV_DEN_W'(shifted - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= shifted[DIV_DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DIV_NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/rgbhsi_back.sv -----
// ---------------------------------------------------------------------------
// rgbhsi_back
// Conversion engine: saturation and hue, CORDIC angle, frame sums and means.
// ---------------------------------------------------------------------------
module rgbhsi_back
    import rgbhsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  item_t                q_item,
    input  fifo_status_t         q_status,
    output logic                 q_pop,
    output logic                 div_start,
    output logic [DIV_NUM_W-1:0] div_dividend,
    output logic [DIV_DEN_W-1:0] div_divisor,
    input  logic                 div_done,
    input  logic [DIV_NUM_W-1:0] div_quotient,
    input  logic                 pop,
    output logic                 empty,
    output result_t              result
);

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [15:0]        sq_reg, sq_next;
    logic [15:0]        hq_reg, hq_next;
    logic [17:0]        hnum_reg, hnum_next;
    logic signed [27:0] x_reg, x_next;
    logic signed [27:0] y_reg, y_next;
    logic signed [26:0] z_reg, z_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [18:0]        count_reg, count_next;
    logic [33:0]        isum_reg, isum_next;
    logic [33:0]        ssum_reg, ssum_next;
    logic [33:0]        hsum_reg, hsum_next;
    logic [15:0]        mi_reg, mi_next;
    logic [15:0]        ms_reg, ms_next;
    logic [15:0]        mh_reg, mh_next;
    logic [1:0]         sel_reg, sel_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [27:0] dx;
    logic signed [27:0] dy;
    logic signed [26:0] angle;
    logic [24:0]        theta;
    logic [28:0]        hue17;
    logic [35:0]        hue_recip;

    function automatic logic signed [27:0] shr0(input logic signed [27:0] v,
                                                input logic [STEP_W-1:0] s);
        logic signed [27:0] r;
        if (v[27])
        begin
            r = -((-v) >>> s);
        end
        else
        begin
            r = v >>> s;
        end
        return r;
    endfunction

    assign empty = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        sq_reg <= sq_next;
        hq_reg <= hq_next;
        hnum_reg <= hnum_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        mi_reg <= mi_next;
        ms_reg <= ms_next;
        mh_reg <= mh_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            sel_reg <= 2'd0;
            count_reg <= '0;
            isum_reg <= '0;
            ssum_reg <= '0;
            hsum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            sel_reg <= sel_next;
            count_reg <= count_next;
            isum_reg <= isum_next;
            ssum_reg <= ssum_next;
            hsum_reg <= hsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        sq_next = sq_reg;
        hq_next = hq_reg;
        hnum_next = hnum_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        step_next = step_reg;
        count_next = count_reg;
        isum_next = isum_reg;
        ssum_next = ssum_reg;
        hsum_next = hsum_reg;
        mi_next = mi_reg;
        ms_next = ms_reg;
        mh_next = mh_reg;
        sel_next = sel_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        q_pop = 1'b0;
        div_start = 1'b0;
        div_dividend = '0;
        div_divisor = '0;

        dx = shr0(y_reg, step_reg);
        dy = shr0(x_reg, step_reg);
        if (z_reg < 0)
        begin
            angle = 27'sd0;
        end
        else if (z_reg > ANGLE_180)
        begin
            angle = ANGLE_180;
        end
        else
        begin
            angle = z_reg;
        end
        if (item_reg.b_gt_g)
        begin
            theta = ANGLE_360 - 25'(angle);
        end
        else
        begin
            theta = 25'(angle);
        end
        hue17 = 29'(theta) * 29'd17;
        hue_recip = 36'(hnum_reg) * 36'(HUE_RECIP);

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop = 1'b1;
                    item_next = q_item;
                    x_next = q_item.x0;
                    y_next = q_item.y0;
                    z_next = q_item.z0;
                    step_next = '0;
                    mi_next = '0;
                    ms_next = '0;
                    mh_next = '0;
                    if (q_item.gray)
                    begin
                        sq_next = '0;
                        hq_next = '0;
                        state_next = ST_ACCUM;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_dividend = DIV_NUM_W'(q_item.sat_num);
                        div_divisor = DIV_DEN_W'(q_item.tsum);
                        state_next = ST_SAT;
                    end
                end
            end
            ST_SAT:
            begin
                if (div_done)
                begin
                    sq_next = div_quotient[15:0];
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_q16(step_reg);
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_q16(step_reg);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_HUE_START;
                end
            end
            ST_HUE_START:
            begin
                hnum_next = hue17[28:11];
                state_next = ST_HUE;
            end
            ST_HUE:
            begin
                hq_next = hue_recip[34:19];
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                if (count_reg < MAX_FRAME_PIXELS)
                begin
                    count_next = count_reg + 1'b1;
                    isum_next = isum_reg + 34'(item_reg.iq);
                    ssum_next = ssum_reg + 34'(sq_reg);
                    hsum_next = hsum_reg + 34'(hq_reg);
                end
                sel_next = 2'd0;
                state_next = item_reg.last ? ST_MEAN_START : ST_OUT;
            end
            ST_MEAN_START:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start = 1'b1;
                    div_divisor = count_reg;
                    case (sel_reg)
                        2'd0:    div_dividend = isum_reg;
                        2'd1:    div_dividend = ssum_reg;
                        default: div_dividend = hsum_reg;
                    endcase
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        2'd0:    mi_next = div_quotient[15:0];
                        2'd1:    ms_next = div_quotient[15:0];
                        default: mh_next = div_quotient[15:0];
                    endcase
                    if (sel_reg == 2'd2)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                        state_next = ST_MEAN_START;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next.intensity = item_reg.iq[15:8];
                    out_next.saturation = sq_reg[15:8];
                    out_next.hue = hq_reg[15:8];
                    out_next.frame_done = item_reg.last;
                    out_next.mean_intensity = mi_reg;
                    out_next.mean_saturation = ms_reg;
                    out_next.mean_hue = mh_reg;
                    out_valid_next = 1'b1;
                    if (item_reg.last)
                    begin
                        count_next = '0;
                        isum_next = '0;
                        ssum_next = '0;
                        hsum_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/rgb_to_hsi_converter.sv -----
// ---------------------------------------------------------------------------
// rgb_to_hsi_converter
// Per-pixel RGB to HSI conversion with frame averages of I, S and H.
// ---------------------------------------------------------------------------
// Input is a queue port: drive pixel and push; a beat moves while full is
// low. Results form a queue port too: result holds the oldest beat while
// empty is low, and pop takes it.
// Pixels are classified and enter a two-entry queue; one engine converts
// them one at a time. A gray pixel goes straight to accumulation and output.
// Any other pixel takes a divider pass for saturation, 18 CORDIC steps
// for the angle, hue scaling in ST_HUE_START and ST_HUE, then accumulation
// and output. A frame's last pixel adds three divider passes for the
// averages. The shared serial divider sets the rate.
// Reset clears the queue, the frame count and sums, and the result slot.
// While the receiver stalls the finished beat holds in the result slot; the
// engine stops when it has a new result, and the queue then fills and
// raises full.
// ---------------------------------------------------------------------------
module rgb_to_hsi_converter
    import rgbhsi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  pixel_t  pixel,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    item_t                front_item;
    item_t                q_item;
    fifo_status_t         q_status;
    logic                 q_pop;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_DEN_W-1:0] div_divisor;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quotient;

    assign full = q_status.full;

    rgbhsi_front u_front
    (
        .pixel (pixel),
        .item  (front_item)
    );

    rgbhsi_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_item (front_item),
        .rd      (q_pop),
        .rd_item (q_item),
        .status  (q_status)
    );

    rgbhsi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    rgbhsi_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (q_item),
        .q_status     (q_status),
        .q_pop        (q_pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .pop          (pop),
        .empty        (empty),
        .result       (result)
    );

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("engine took an item from an empty queue");

    a_means_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.frame_done) |->
            (result.mean_intensity == 16'd0 && result.mean_saturation == 16'd0 &&
             result.mean_hue == 16'd0))
        else $error("averages set on a beat that does not end a frame");

    a_start_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> !div_done)
        else $error("divider finished right after start");

endmodule

// ----- tb/tb_rgb_to_hsi_converter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rgb_to_hsi_converter
// Self-checking bench for the RGB to HSI converter with frame averages.
// ---------------------------------------------------------------------------
// Pixels are pushed from a pending queue by a clocked driver. Each accepted
// pixel goes through a local fixed-point model that computes intensity,
// saturation and CORDIC hue, and keeps the frame count and sums. A clocked
// monitor pops results and compares each field with the oldest expected one.
// Both sides idle at random. The receiver holds off once for a long stretch
// so that the block fills up and stalls its input. A stretch in the middle
// runs with no idling on either side.
// ---------------------------------------------------------------------------
module tb_rgb_to_hsi_converter;
    import rgbhsi_pkg::*;

    localparam int MAX_PIX = 262144;
    localparam int RANDOM_ITEMS = 1150;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int NO_IDLE_START = 300;
    localparam int NO_IDLE_LEN = 200;

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    pixel_t  pixel;
    logic    pop;
    logic    empty;
    result_t result;

    pixel_t  pending_pixels[$];
    result_t hsi_expected[$];

    longint unsigned frame_count;
    longint unsigned frame_isum;
    longint unsigned frame_ssum;
    longint unsigned frame_hsum;

    int  n_pushed;
    int  n_popped;
    int  errors;
    int  stall_cycles;
    int  hold_left;
    bit  hold_done;
    longint atan_lut[CORDIC_STEPS];

    rgb_to_hsi_converter i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .pixel  (pixel),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic longint shift_trunc(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v) >>> s);
    endfunction

    function automatic longint hue_angle(longint r, longint g, longint b);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        x = (2 * r - g - b) * 65536;
        y = ((g >= b) ? g - b : b - g) * 113512;
        z = 0;
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = 90 * 65536;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = shift_trunc(y, i);
            dy = shift_trunc(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += atan_lut[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_lut[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > 180 * 65536)
            z = 180 * 65536;
        return z;
    endfunction

    function automatic result_t convert_pixel(pixel_t p);
        result_t         res;
        longint unsigned r;
        longint unsigned g;
        longint unsigned b;
        longint unsigned tot;
        longint unsigned mn;
        longint unsigned iq;
        longint unsigned sq;
        longint unsigned hq;
        longint          theta;
        r = p.red;
        g = p.green;
        b = p.blue;
        tot = r + g + b;
        mn = (r < g) ? r : g;
        if (mn > b)
            mn = b;
        iq = tot * 256 / 3;
        sq = 0;
        hq = 0;
        if (!(r == g && g == b))
        begin
            sq = 65280 * (tot - 3 * mn) / tot;
            theta = hue_angle(r, g, b);
            if (b > g)
                theta = 360 * 65536 - theta;
            hq = longint'(theta) * 255 / (360 * 256);
            if (hq > 65535)
                hq = 65535;
        end
        if (frame_count < MAX_PIX)
        begin
            frame_count = frame_count + 1;
            frame_isum = (frame_isum + iq) & 64'h3_FFFF_FFFF;
            frame_ssum = (frame_ssum + sq) & 64'h3_FFFF_FFFF;
            frame_hsum = (frame_hsum + hq) & 64'h3_FFFF_FFFF;
        end
        res = '0;
        res.intensity = iq[15:8];
        res.saturation = sq[15:8];
        res.hue = hq[15:8];
        res.frame_done = p.last_pixel;
        if (p.last_pixel)
        begin
            if (frame_count != 0)
            begin
                res.mean_intensity = 16'(frame_isum / frame_count);
                res.mean_saturation = 16'(frame_ssum / frame_count);
                res.mean_hue = 16'(frame_hsum / frame_count);
            end
            frame_count = 0;
            frame_isum = 0;
            frame_ssum = 0;
            frame_hsum = 0;
        end
        return res;
    endfunction

    function automatic pixel_t make_pixel(int r, int g, int b, bit last);
        pixel_t p;
        p.red = 8'(r);
        p.green = 8'(g);
        p.blue = 8'(b);
        p.last_pixel = last;
        return p;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            pixel <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                hsi_expected.push_back(convert_pixel(pixel));
                n_pushed++;
            end
            if (!push || !full)
            begin
                if (pending_pixels.size() != 0 &&
                    (n_pushed >= NO_IDLE_START && n_pushed < NO_IDLE_START + NO_IDLE_LEN ||
                     $urandom_range(99) >= 33))
                begin
                    pixel <= pending_pixels.pop_front();
                    push <= 1'b1;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                n_popped++;
                if (hsi_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %p", $time, result);
                    errors++;
                end
                else if (result !== hsi_expected[0])
                begin
                    $display("%0t: mismatch, expected %p, actual %p", $time,
                             hsi_expected[0], result);
                    errors++;
                    void'(hsi_expected.pop_front());
                end
                else
                begin
                    void'(hsi_expected.pop_front());
                end
            end
            if (!hold_done && n_popped == 40)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (n_popped >= NO_IDLE_START && n_popped < NO_IDLE_START + NO_IDLE_LEN)
            begin
                pop <= 1'b1;
            end
            else
            begin
                pop <= ($urandom_range(99) >= 33);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (push && !full) || (pop && !empty))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int g;
        bit last;
        atan_lut = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                     14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
        frame_count = 0;
        frame_isum = 0;
        frame_ssum = 0;
        frame_hsum = 0;
        n_pushed = 0;
        n_popped = 0;
        errors = 0;
        stall_cycles = 0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        pixel = '0;

        // directed: extremes, gray, hue quadrants, lone last pixel
        pending_pixels.push_back(make_pixel(0, 0, 0, 1));
        pending_pixels.push_back(make_pixel(255, 255, 255, 0));
        pending_pixels.push_back(make_pixel(128, 128, 128, 0));
        pending_pixels.push_back(make_pixel(255, 0, 0, 0));
        pending_pixels.push_back(make_pixel(0, 255, 0, 0));
        pending_pixels.push_back(make_pixel(0, 0, 255, 0));
        pending_pixels.push_back(make_pixel(255, 255, 0, 0));
        pending_pixels.push_back(make_pixel(0, 255, 255, 0));
        pending_pixels.push_back(make_pixel(255, 0, 255, 1));
        pending_pixels.push_back(make_pixel(1, 0, 0, 0));
        pending_pixels.push_back(make_pixel(0, 0, 1, 0));
        pending_pixels.push_back(make_pixel(0, 1, 0, 0));
        pending_pixels.push_back(make_pixel(254, 255, 255, 0));
        pending_pixels.push_back(make_pixel(255, 254, 255, 0));
        pending_pixels.push_back(make_pixel(255, 255, 254, 0));
        pending_pixels.push_back(make_pixel(200, 100, 101, 0));
        pending_pixels.push_back(make_pixel(200, 101, 100, 0));
        pending_pixels.push_back(make_pixel(10, 200, 200, 0));
        pending_pixels.push_back(make_pixel(170, 85, 0, 1));
        pending_pixels.push_back(make_pixel(255, 255, 255, 1));

        for (int i = 0; i < 80; i++)
            pending_pixels.push_back(make_pixel($urandom_range(255), $urandom_range(255),
                                                $urandom_range(255),
                                                $urandom_range(7) == 0));
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            last = ($urandom_range(15) == 0);
            if ($urandom_range(9) == 0)
            begin
                g = $urandom_range(255);
                pending_pixels.push_back(make_pixel(g, g, g, last));
            end
            else
            begin
                pending_pixels.push_back(make_pixel($urandom_range(255), $urandom_range(255),
                                                    $urandom_range(255), last));
            end
        end
        pending_pixels.push_back(make_pixel(255, 255, 255, 1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_pixels.size() == 0 && !push);
        wait (hsi_expected.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0 && hsi_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
